// ===== hdl/running_mean_variance_tracker_unit_assert.svh =====
// assertion macros for the running mean and variance tracker
`ifndef RUNNING_MEAN_VARIANCE_TRACKER_UNIT_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_TRACKER_UNIT_ASSERT_SVH

// property must hold at every edge out of reset
`define RMVT_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen out of reset
`define RMVT_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== hdl/rmvt_pkg.sv =====
// shared constants, codes and types of the running mean and variance tracker
`default_nettype none
package rmvt_pkg;
  localparam int SampleBits = 16;
  localparam int FracBits   = 16;
  localparam int MaxBatch   = 4096;
  localparam int CntW       = 13;
  localparam int SumW       = 29;
  localparam int SqW        = 43;
  localparam int MeanW      = 32;
  localparam int VarW       = 46;
  localparam int CountW     = 32;
  localparam int WeightW    = 16;
  localparam int AluAW      = 72;
  localparam int AluBW      = 48;
  localparam int DivW       = 33;
  localparam int AluCntW    = 7;
  localparam logic [VarW-1:0] VarReset = VarW'(7);
  localparam logic [VarW-1:0] VarMax   = {VarW{1'b1}};

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_ZERO = 2'd1,
    STS_SAT  = 2'd2,
    STS_OVF  = 2'd3
  } status_e;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic             start;
    alu_op_e          op;
    logic [AluAW-1:0] a;
    logic [AluBW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [AluAW-1:0] res;
  } alu_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/rmvt_alu.sv =====
// shared shift-add multiplier and restoring divider, one bit per cycle
`default_nettype none
module rmvt_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rmvt_pkg::alu_req_t req_i,
  output rmvt_pkg::alu_rsp_t      rsp_o
);
  import rmvt_pkg::*;

  logic               busy_q, busy_d;
  alu_op_e            op_q, op_d;
  logic [AluCntW-1:0] cnt_q, cnt_d;
  logic [AluAW-1:0]   opa_q, opa_d;
  logic [AluBW-1:0]   opb_q, opb_d;
  logic [AluAW-1:0]   acc_q, acc_d;
  logic [DivW:0]      rem_q, rem_d;
  logic [DivW:0]      trial;
  logic               fits;
  logic               last_iter;

  assign trial     = {rem_q[DivW-1:0], opa_q[AluAW-1]};
  assign fits      = trial >= {1'b0, opb_q[DivW-1:0]};
  assign last_iter = (cnt_q == AluCntW'(1));

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = (req_i.op == ALU_MUL) ? AluCntW'(AluBW) : AluCntW'(AluAW);
      opa_d  = req_i.a;
      opb_d  = req_i.b;
      acc_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - AluCntW'(1);
      if (last_iter) busy_d = 1'b0;
      unique case (op_q)
        ALU_MUL: begin
          if (opb_q[0]) acc_d = acc_q + opa_q;
          opa_d = {opa_q[AluAW-2:0], 1'b0};
          opb_d = {1'b0, opb_q[AluBW-1:1]};
        end
        ALU_DIV: begin
          rem_d = fits ? trial - {1'b0, opb_q[DivW-1:0]} : trial;
          opa_d = {opa_q[AluAW-2:0], 1'b0};
          acc_d = {acc_q[AluAW-2:0], fits};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_MUL;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q <= opa_d;
    opb_q <= opb_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  // done is raised the cycle after the final iteration
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= busy_q && last_iter && !req_i.start;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;
endmodule
`default_nettype wire

// ===== hdl/running_mean_variance_tracker_unit.sv =====
// running mean and variance tracker: sample accumulators, merge sequencer and state
//
// Input channel s_axis: one signed sample per item, tlast marks the last sample of a
// batch, and the batch weight in tdata is read on that last item only. Ordinary
// samples are taken at one per cycle and summed together with their squares.
// On a last item the block drops tready and a sequencer runs the batch statistics
// and the merge through one shared shift-add multiplier / restoring divider:
// six multiplies and four divides in turn, at one bit per cycle of the shared unit.
// A zero total weight skips the merge and gives its result in the next cycle.
// Output channel m_axis: one item per batch with mean, variance, count and status.
// The result stays on m_axis until taken; tready on s_axis stays low meanwhile,
// so a stalled receiver holds off the next sample.
// Reset clears the batch accumulators, mean and count, and sets the variance to 7
// (about 1e-4 with 16 fraction bits).
`default_nettype none
`include "running_mean_variance_tracker_unit_assert.svh"
module running_mean_variance_tracker_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [31:0]   s_axis_tdata,  // sample[15:0], batch_weight[31:16]
  input  wire logic          s_axis_tlast,  // last_of_batch
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [111:0]       m_axis_tdata   // mean[31:0], variance[77:32],
                                            // count[109:78], status[111:110]
);
  import rmvt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  typedef enum logic [9:0] {
    STP_NQ  = 10'b0000000001,
    STP_S2  = 10'b0000000010,
    STP_DEN = 10'b0000000100,
    STP_BM  = 10'b0000001000,
    STP_BV  = 10'b0000010000,
    STP_DW  = 10'b0000100000,
    STP_A   = 10'b0001000000,
    STP_VW  = 10'b0010000000,
    STP_VT  = 10'b0100000000,
    STP_PR  = 10'b1000000000
  } step_e;

  state_e state_q;
  step_e  step_q;

  logic signed [SumW-1:0] sum_q;
  logic [SqW-1:0]         sq_q;
  logic [CntW-1:0]        n_q;
  logic                   ovf_q;
  logic signed [MeanW-1:0] mean_q;
  logic [VarW-1:0]        var_q;
  logic [CountW-1:0]      cnt_q;
  status_e                status_q;

  logic [WeightW-1:0]     w_q;
  logic [CountW:0]        total_q;
  logic [55:0]            nq_q;
  logic [55:0]            dsq_q;
  logic [25:0]            den_q;
  logic signed [33:0]     bm_q;
  logic [VarW-1:0]        bv_q;
  logic signed [33:0]     d_q;
  logic signed [33:0]     a_q;
  logic [AluAW-1:0]       t_q;
  logic signed [47:0]     vt_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  rmvt_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // input side
  logic signed [SampleBits-1:0] smp;
  logic [SampleBits-1:0]        smp_mag;
  logic [2*SampleBits-1:0]      smp_sq;
  logic [WeightW-1:0]           in_w;
  logic [CountW:0]              in_total;
  logic                         in_acc;
  logic                         room;

  assign smp      = s_axis_tdata[15:0];
  assign in_w     = s_axis_tdata[31:16];
  assign smp_mag  = smp[SampleBits-1] ? SampleBits'(-smp) : SampleBits'(smp);
  assign smp_sq   = smp_mag * smp_mag;
  assign in_total = {1'b0, cnt_q} + (CountW+1)'(in_w);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign room     = n_q < CntW'(MaxBatch);

  // magnitudes feeding the shared unit
  logic [27:0]        sum_mag;
  logic [32:0]        d_mag;
  logic signed [46:0] dv;
  logic [45:0]        dv_mag;
  logic [32:0]        a_mag;
  logic signed [33:0] dma;
  logic [32:0]        dma_mag;
  logic [33:0]        sum_neg;
  logic [33:0]        d_neg;
  logic [46:0]        dv_neg;
  logic [33:0]        a_neg;
  logic [33:0]        dma_neg;

  assign sum_neg = 34'(-34'(sum_q));
  assign sum_mag = sum_q[SumW-1] ? sum_neg[27:0] : 28'(sum_q);
  assign d_neg   = -d_q;
  assign d_mag   = d_q[33] ? d_neg[32:0] : d_q[32:0];
  assign dv      = $signed({1'b0, bv_q}) - $signed({1'b0, var_q});
  assign dv_neg  = -dv;
  assign dv_mag  = dv[46] ? dv_neg[45:0] : dv[45:0];
  assign a_neg   = -a_q;
  assign a_mag   = a_q[33] ? a_neg[32:0] : a_q[32:0];
  assign dma     = d_q - a_q;
  assign dma_neg = -dma;
  assign dma_mag = dma[33] ? dma_neg[32:0] : dma[32:0];

  always_comb begin
    alu_req.start = (state_q == ST_IDLE) ? 1'b0 : (state_q == ST_ISSUE);
    alu_req.op    = ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (step_q)
      STP_NQ: begin
        alu_req.a = AluAW'(sq_q);
        alu_req.b = AluBW'(n_q);
      end
      STP_S2: begin
        alu_req.a = AluAW'(sum_mag);
        alu_req.b = AluBW'(sum_mag);
      end
      STP_DEN: begin
        alu_req.a = AluAW'(n_q);
        alu_req.b = AluBW'(n_q);
      end
      STP_BM: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = AluAW'({sum_mag, {FracBits{1'b0}}}) + AluAW'(n_q >> 1);
        alu_req.b  = AluBW'(n_q);
      end
      STP_BV: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = AluAW'({dsq_q, {FracBits{1'b0}}}) + AluAW'(den_q >> 1);
        alu_req.b  = AluBW'(den_q);
      end
      STP_DW: begin
        alu_req.a = AluAW'(d_mag);
        alu_req.b = AluBW'(w_q);
      end
      STP_A, STP_VT: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = t_q + AluAW'(total_q >> 1);
        alu_req.b  = AluBW'(total_q);
      end
      STP_VW: begin
        alu_req.a = AluAW'(dv_mag);
        alu_req.b = AluBW'(w_q);
      end
      STP_PR: begin
        alu_req.a = AluAW'(a_mag);
        alu_req.b = AluBW'(dma_mag);
      end
      default: ;
    endcase
  end

  // results of the shared unit
  logic [AluAW-1:0]   res;
  logic [33:0]        res_neg;
  logic [47:0]        res_neg48;
  logic [AluAW-1:0]   prod_rnd;
  logic signed [51:0] vsum;
  logic               var_clamp;

  assign res       = alu_rsp.res;
  assign res_neg   = -res[33:0];
  assign res_neg48 = -res[47:0];
  assign prod_rnd  = (res + AluAW'(1 << (FracBits - 1))) >> FracBits;
  assign vsum      = $signed({6'b0, var_q}) + 52'(vt_q) + $signed(prod_rnd[51:0]);
  assign var_clamp = vsum[51] || (vsum[50:VarW] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= STP_NQ;
      sum_q    <= '0;
      sq_q     <= '0;
      n_q      <= '0;
      ovf_q    <= 1'b0;
      mean_q   <= '0;
      var_q    <= VarReset;
      cnt_q    <= '0;
      status_q <= STS_OK;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tlast && in_total == '0) begin
              sum_q    <= '0;
              sq_q     <= '0;
              n_q      <= '0;
              ovf_q    <= 1'b0;
              status_q <= STS_ZERO;
              state_q  <= ST_OUT;
            end else begin
              if (room) begin
                sum_q <= sum_q + SumW'(smp);
                sq_q  <= sq_q + SqW'(smp_sq);
                n_q   <= n_q + CntW'(1);
              end else begin
                ovf_q <= 1'b1;
              end
              if (s_axis_tlast) begin
                step_q  <= STP_NQ;
                state_q <= ST_ISSUE;
              end
            end
          end
        end
        ST_ISSUE: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (alu_rsp.done) begin
            state_q <= ST_ISSUE;
            unique case (step_q)
              STP_NQ:  step_q <= STP_S2;
              STP_S2:  step_q <= STP_DEN;
              STP_DEN: step_q <= STP_BM;
              STP_BM:  step_q <= STP_BV;
              STP_BV:  step_q <= STP_DW;
              STP_DW:  step_q <= STP_A;
              STP_A:   step_q <= STP_VW;
              STP_VW:  step_q <= STP_VT;
              STP_VT:  step_q <= STP_PR;
              STP_PR: begin
                step_q  <= STP_NQ;
                state_q <= ST_OUT;
                mean_q  <= mean_q + a_q[MeanW-1:0];
                var_q   <= var_clamp ? VarMax : vsum[VarW-1:0];
                if (ovf_q) status_q <= STS_OVF;
                else if (total_q[CountW]) status_q <= STS_SAT;
                else status_q <= STS_OK;
                cnt_q   <= total_q[CountW] ? {CountW{1'b1}} : total_q[CountW-1:0];
                sum_q   <= '0;
                sq_q    <= '0;
                n_q     <= '0;
                ovf_q   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (m_axis_tready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath temporaries
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      w_q     <= in_w;
      total_q <= in_total;
    end
    if (state_q == ST_WAIT && alu_rsp.done) begin
      unique case (step_q)
        STP_NQ:  nq_q  <= res[55:0];
        STP_S2:  dsq_q <= (nq_q > res[55:0]) ? nq_q - res[55:0] : '0;
        STP_DEN: den_q <= res[25:0];
        STP_BM:  bm_q  <= sum_q[SumW-1] ? $signed(res_neg) : $signed(res[33:0]);
        STP_BV: begin
          bv_q <= (res > AluAW'(VarMax)) ? VarMax : res[VarW-1:0];
          d_q  <= bm_q - 34'(mean_q);
        end
        STP_DW:  t_q  <= res;
        STP_A:   a_q  <= d_q[33] ? $signed(res_neg) : $signed(res[33:0]);
        STP_VW:  t_q  <= res;
        STP_VT:  vt_q <= dv[46] ? $signed(res_neg48) : $signed(res[47:0]);
        STP_PR:  ;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {status_q, cnt_q, var_q, mean_q};

  `RMVT_ASSERT_NEVER(a_one_side, clk_i, rst_ni, s_axis_tready && m_axis_tvalid,
                     "input taken while a result is pending")
  `RMVT_ASSERT(a_done_in_wait, clk_i, rst_ni, alu_rsp.done |-> state_q == ST_WAIT,
               "shared unit finished outside the wait state")
  `RMVT_ASSERT(a_batch_cap, clk_i, rst_ni, n_q <= CntW'(MaxBatch),
               "batch count beyond its cap")
endmodule
`default_nettype wire

// ===== verif/running_mean_variance_tracker_unit_tb.sv =====
// testbench of the running mean and variance tracker: directed and random batches checked against a predictor
`default_nettype none
module running_mean_variance_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmvt_pkg::*;

  typedef struct {
    logic [15:0] sample;
    logic        last;
    logic [15:0] weight;
  } sample_item_t;

  typedef struct {
    logic [MeanW-1:0]  mean;
    logic [VarW-1:0]   variance;
    logic [CountW-1:0] count;
    status_e           status;
  } stats_t;

  localparam int StallLimit = 50000;
  localparam int LongHold   = 3000;
  localparam int DrainWait  = 800;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;

  sample_item_t pending_q[$];
  stats_t       expected_stats_q[$];
  int           tx_idle_pct = 16;
  int           rx_idle_pct = 84;
  bit           sender_hold = 1'b0;
  bit           hold_request = 1'b0;
  int           hold_left = 0;
  int           errors = 0;
  int           samples_in = 0;
  int           batches_out = 0;
  int           zero_seen = 0;
  int           ovf_seen = 0;
  int           quiet_cycles = 0;

  // predictor state
  longint          acc_sum;
  longint unsigned acc_sq;
  int              acc_n;
  bit              acc_ovf;
  longint          run_mean;
  longint unsigned run_var;
  longint unsigned run_cnt;

  running_mean_variance_tracker_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #6 clk_i = ~clk_i;

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  // division rounded to nearest, ties away from zero
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned q;
    q = (magnitude(num) + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void clear_batch();
    acc_sum = 0;
    acc_sq  = 0;
    acc_n   = 0;
    acc_ovf = 1'b0;
  endfunction

  function automatic stats_t snapshot(status_e st);
    stats_t r;
    r.mean     = run_mean[MeanW-1:0];
    r.variance = run_var[VarW-1:0];
    r.count    = run_cnt[CountW-1:0];
    r.status   = st;
    return r;
  endfunction

  function automatic void track_sample(sample_item_t it);
    longint          s, bm, d, a, dv;
    longint unsigned w, total, n, den, sm, nq, s2, dsq, q, r, bv, v, prod;
    status_e         st;
    s = longint'($signed(it.sample));
    w = it.weight;
    if (acc_n < MaxBatch) begin
      acc_sum += s;
      acc_sq  += magnitude(s) * magnitude(s);
      acc_n++;
    end else begin
      acc_ovf = 1'b1;
    end
    if (!it.last) return;
    total = run_cnt + w;
    if (total == 0 || acc_n == 0) begin
      clear_batch();
      expected_stats_q.push_back(snapshot(STS_ZERO));
      return;
    end
    n   = acc_n;
    bm  = round_div(acc_sum * 65536, n);
    den = n * n;
    sm  = magnitude(acc_sum);
    nq  = n * acc_sq;
    s2  = sm * sm;
    dsq = nq > s2 ? nq - s2 : 0;
    q   = dsq / den;
    r   = dsq % den;
    bv  = (q << FracBits) + ((r << FracBits) + den / 2) / den;
    if (bv > VarMax) bv = VarMax;
    d    = bm - run_mean;
    a    = round_div(d * longint'(w), total);
    dv   = longint'(bv) - longint'(run_var);
    v    = longint'(run_var) + round_div(dv * longint'(w), total);
    prod = magnitude(a) * magnitude(d - a);
    v   += (prod + (64'd1 << (FracBits - 1))) >> FracBits;
    if (v > VarMax) v = VarMax;
    run_mean += a;
    run_var   = v;
    st = STS_OK;
    if (total > 64'hFFFF_FFFF) begin
      total = 64'hFFFF_FFFF;
      st    = STS_SAT;
    end
    run_cnt = total;
    if (acc_ovf) st = STS_OVF;
    clear_batch();
    expected_stats_q.push_back(snapshot(st));
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_q.size() > 0 && !sender_hold && $urandom_range(99) >= tx_idle_pct) begin
        sample_item_t it;
        it = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.weight, it.sample};
        s_axis_tlast  <= it.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // accepted input items feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sample_item_t it;
      it.sample = s_axis_tdata[15:0];
      it.weight = s_axis_tdata[31:16];
      it.last   = s_axis_tlast;
      track_sample(it);
      samples_in++;
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= LongHold;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= rx_idle_pct;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_stats_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        stats_t e;
        e = expected_stats_q.pop_front();
        if (m_axis_tdata[31:0] !== e.mean) begin
          $error("running_mean_out: expected %h, got %h", e.mean, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[77:32] !== e.variance) begin
          $error("running_variance_out: expected %h, got %h", e.variance,
                 m_axis_tdata[77:32]);
          errors++;
        end
        if (m_axis_tdata[109:78] !== e.count) begin
          $error("running_count_out: expected %h, got %h", e.count, m_axis_tdata[109:78]);
          errors++;
        end
        if (m_axis_tdata[111:110] !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_axis_tdata[111:110]);
          errors++;
        end
        if (e.status == STS_ZERO) zero_seen++;
        if (e.status == STS_OVF) ovf_seen++;
      end
      batches_out++;
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'(signed'($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_batch(int len, logic [15:0] w, bit fixed, logic [15:0] value);
    sample_item_t it;
    for (int i = 0; i < len; i++) begin
      it.sample = fixed ? value : pick_sample();
      it.last   = (i == len - 1);
      // weight bits on non-last items are ignored but still toggled
      it.weight = it.last ? w : 16'($urandom);
      pending_q.push_back(it);
    end
  endtask

  task automatic feed_random(int upto);
    while (samples_in < upto) begin
      queue_batch($urandom_range(9) == 0 ? $urandom_range(13, 64) : $urandom_range(1, 12),
                  pick_weight(), 1'b0, '0);
      while (pending_q.size() > 16) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || s_axis_tvalid || expected_stats_q.size() > 0)
      @(negedge clk_i);
  endtask

  initial begin
    clear_batch();
    run_mean = 0;
    run_var  = VarReset;
    run_cnt  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero total weight first, then extremes of sample and weight
    queue_batch(1, 16'd0, 1'b1, 16'h0005);
    queue_batch(3, 16'd0, 1'b1, 16'h8000);
    queue_batch(1, 16'd1, 1'b1, 16'h7FFF);
    queue_batch(4, 16'hFFFF, 1'b1, 16'h8000);
    queue_batch(4, 16'd0, 1'b1, 16'h7FFF);
    queue_batch(2, 16'hFFFF, 1'b1, 16'h7FFF);
    queue_batch(5, 16'd3, 1'b0, '0);
    queue_batch(4, 16'd1, 1'b1, 16'h0000);
    // sender pauses until every result is back
    wait_drained();

    // build up a backlog, then starve the output for a long stretch
    queue_batch(8, 16'd100, 1'b0, '0);
    queue_batch(8, 16'd200, 1'b0, '0);
    queue_batch(8, 16'd300, 1'b0, '0);
    @(negedge clk_i);
    hold_request = 1'b1;
    feed_random(290);

    tx_idle_pct = 84;
    rx_idle_pct = 16;
    feed_random(570);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    feed_random(830);

    wait_drained();
    repeat (DrainWait) @(negedge clk_i);
    $display("covered %0d samples, %0d batch results (%0d zero weight, %0d overflow)",
             samples_in, batches_out, zero_seen, ovf_seen);
    $display("idling mixes on both sides, extreme samples and weights, a long output stall");
    if (errors == 0 && expected_stats_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
